// File: rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

    localparam logic [5:0] RADIX_MIN  = 6'd2;
    localparam logic [5:0] RADIX_MAX  = 6'd36;
    localparam logic [5:0] RADIX_TEN  = 6'd10;
    localparam logic [5:0] RADIX_RST  = 6'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FETCH,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // digits 0-9 then A-Z
    function automatic logic [7:0] f_glyph(input logic [5:0] digit);
        logic [7:0] g;
        if (digit < 6'd10) begin
            g = CHAR_ZERO + {2'b00, digit};
        end else begin
            g = CHAR_A + {2'b00, digit} - 8'd10;
        end
        return g;
    endfunction

endpackage

// File: rtl/itoa_div.sv
`timescale 1ns / 1ps

module itoa_div import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [5:0]             i_radix,
    output t_div_stat              o_stat,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [5:0]             o_remainder
);

    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CW-1:0]          r_cnt,  n_cnt;
    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [5:0]             r_rem,  n_rem;

    logic [6:0] rem_sh;
    logic [6:0] diff;
    logic       ge;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, i_radix};
    assign ge     = (rem_sh >= {1'b0, i_radix});

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quot = r_quot;
        n_rem  = r_rem;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = 6'd0;
            n_busy = 1'b1;
            n_cnt  = CW'(VALUE_WIDTH - 1);
        end else if (r_busy) begin
            n_quot = {r_quot[VALUE_WIDTH-2:0], ge};
            n_rem  = ge ? diff[5:0] : rem_sh[5:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_radix))
        else $error("remainder not below radix");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("division did not start");

endmodule

// File: rtl/int_to_ascii_radix.sv
`timescale 1ns / 1ps
// Each digit is one bit-serial division by the radix, one quotient bit per cycle.
// A new value is taken only while idle (o_stall low); characters leave one per cycle
// while i_stall does not hold the output.
// Reset: synchronous active low; idle, output empty, number_base back to 10.

module int_to_ascii_radix import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [5:0]                    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_character,
    output logic                          o_last_char
);

    localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    t_state r_state, n_state;

    logic [5:0]    r_number_base;
    logic [5:0]    r_radix, n_radix;
    logic          r_neg,   n_neg;
    logic [AW-1:0] r_nd,    n_nd;
    logic [AW-1:0] r_idx,   n_idx;
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_char,  n_char;
    logic          r_last,  n_last;

    logic [5:0] mem [VALUE_WIDTH];
    logic [5:0] r_rd_data;
    logic       mem_we;

    logic [5:0]             eff_radix;
    logic                   is_neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   out_free;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    t_div_stat              div_stat;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [5:0]             div_rem;
    logic                   quot_zero;

    always_comb begin
        if (r_number_base < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (r_number_base > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_number_base;
        end
    end

    assign is_neg       = (eff_radix == RADIX_TEN) && i_value[VALUE_WIDTH-1];
    assign mag          = is_neg ? (~$unsigned(i_value) + 1'b1) : $unsigned(i_value);
    assign out_free     = !r_ovalid || !i_stall;
    assign quot_zero    = (div_quot == '0);
    assign div_dividend = (r_state == S_IDLE) ? mag : div_quot;

    itoa_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_radix     (r_radix),
        .o_stat      (div_stat),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done && quot_zero) n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = r_neg ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                if (out_free) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free && r_idx == '0) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_radix   = r_radix;
        n_neg     = r_neg;
        n_nd      = r_nd;
        n_idx     = r_idx;
        n_ovalid  = r_ovalid && i_stall;
        n_char    = r_char;
        n_last    = r_last;
        div_start = 1'b0;
        mem_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_radix   = eff_radix;
                    n_neg     = is_neg;
                    n_nd      = '0;
                    div_start = 1'b1;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    // store digits least significant first
                    mem_we = 1'b1;
                    n_nd   = r_nd + 1'b1;
                    if (quot_zero) begin
                        n_idx = r_nd;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            S_FETCH: begin
            end
            S_SIGN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_MINUS;
                    n_last   = 1'b0;
                end
            end
            S_EMIT: begin
                // read back most significant first
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = f_glyph(r_rd_data);
                    n_last   = (r_idx == '0);
                    if (r_idx != '0) n_idx = r_idx - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_nd] <= div_rem;
        r_rd_data <= mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_number_base <= RADIX_RST;
            r_ovalid      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_number_base <= i_cfg_data;
        end
        r_radix <= n_radix;
        r_neg   <= n_neg;
        r_nd    <= n_nd;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("division finished outside conversion");

    a_sign_radix_ten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |-> (r_neg && r_radix == RADIX_TEN))
        else $error("sign emitted outside radix ten");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_char == CHAR_MINUS) |-> !r_last)
        else $error("minus flagged as last character");

endmodule
